>>> src/kcl_pkg.sv
// Shared constants, phase codes and key-scan helper for the keypad code lock.
// No dependencies; used by keypad_code_lock_top.
package kcl_pkg;

  localparam int unsigned CodeLength = 4;
  localparam int unsigned Rows       = 4;
  localparam int unsigned Cols       = 4;
  localparam int unsigned KeyW       = 4;
  localparam int unsigned PosW       = (CodeLength > 1) ? $clog2(CodeLength) : 1;

  localparam logic [KeyW-1:0] KeyHash = 4'd14;
  localparam logic [KeyW-1:0] KeyZero = 4'd13;

  // Debounce machine phase codes
  localparam logic [1:0] PhScanning = 2'd0;
  localparam logic [1:0] PhDebounce = 2'd1;
  localparam logic [1:0] PhHold     = 2'd2;

  // Register indexes on the configuration port
  localparam logic [1:0] CfgCodeWord      = 2'd0;
  localparam logic [1:0] CfgDebounceTicks = 2'd1;
  localparam logic [1:0] CfgAttemptLimit  = 2'd2;

  localparam logic [15:0] CodeWordRst      = 16'h9999;
  localparam logic [7:0]  DebounceTicksRst = 8'd5;
  localparam logic [3:0]  AttemptLimitRst  = 4'd5;

  typedef struct packed {
    logic            found;
    logic [KeyW-1:0] idx;
  } scan_t;

  // First pressed key in row-major order; independent bits, priority pick.
  function automatic scan_t first_pressed(logic [15:0] m);
    scan_t res;
    res.found = 1'b0;
    res.idx   = '0;
    for (int r = Rows - 1; r >= 0; r--) begin
      for (int c = Cols - 1; c >= 0; c--) begin
        if (r * Cols + c < 16) begin
          if (m[r * Cols + c]) begin
            res.found = 1'b1;
            res.idx   = KeyW'(r * Cols + c);
          end
        end
      end
    end
    return res;
  endfunction

endpackage

>>> src/keypad_code_lock_top.sv
// Keypad code lock: debounced 4x4 key matrix scan, code entry ring and lockout.
// Depends on kcl_pkg.
//
// One input item is one matrix snapshot (bit row*4+col set = key down).
// The block takes one item per clock: the whole tick (key pick, debounce step,
// ring update, code compare) is a single pass of logic into the state and
// result registers, so an item is accepted in any cycle in which the result
// register is empty or being taken, and its result shows in the next cycle.
// Every accepted item gives exactly one result item: the released key (if
// any) plus the correct / incorrect / locked flags and the wrong-code count as
// they stand after that tick. A key is released when, while held, the matrix
// reads no key; released keys other than # fill a four-entry ring, and # checks
// the ring against code_word (entry 0 in the low nibble). After a wrong code,
// two # presses clear the flags and the ring. Once the wrong count reaches
// attempt_limit the block locks until reset and only reports its flags.
// Configuration: write enable, index (0 code_word, 1 debounce_ticks,
// 2 attempt_limit, 3 ignored) and data; write only while idle.
module keypad_code_lock_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] key_matrix_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        key_released_valid_o,
  output logic [3:0]  key_released_index_o,
  output logic        code_correct_o,
  output logic        code_incorrect_o,
  output logic        locked_out_o,
  output logic [3:0]  wrong_attempts_o
);

  localparam int unsigned KW = kcl_pkg::KeyW;
  localparam int unsigned CL = kcl_pkg::CodeLength;
  localparam int unsigned PW = kcl_pkg::PosW;

  // configuration registers
  logic [15:0] code_word_q;
  logic [7:0]  debounce_ticks_q;
  logic [3:0]  attempt_limit_q;

  // tick state
  logic [1:0]    scan_phase_q, scan_phase_d;
  logic [KW-1:0] last_key_q, last_key_d;
  logic [7:0]    debounce_count_q, debounce_count_d;
  logic [KW-1:0] entered_keys_q [CL];
  logic [KW-1:0] entered_keys_d [CL];
  logic [PW-1:0] entry_position_q, entry_position_d;
  logic [3:0]    wrong_count_q, wrong_count_d;
  logic          hash_count_q, hash_count_d;
  logic          correct_q, correct_d;
  logic          incorrect_q, incorrect_d;
  logic          locked_q, locked_d;

  // result register
  logic          out_valid_q, out_valid_d;
  logic          rel_valid_q, rel_valid_d;
  logic [KW-1:0] rel_idx_q, rel_idx_d;

  logic          in_acc;
  kcl_pkg::scan_t scan;
  logic          ring_match;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign scan       = kcl_pkg::first_pressed(key_matrix_i);

  // Ring compare; entries past four wrap onto the code word nibbles.
  always_comb begin
    ring_match = 1'b1;
    for (int i = 0; i < CL; i++) begin
      if (entered_keys_q[i] != code_word_q[4 * (i % 4) +: 4]) begin
        ring_match = 1'b0;
      end
    end
  end

  // One tick of the lock
  always_comb begin
    scan_phase_d     = scan_phase_q;
    last_key_d       = last_key_q;
    debounce_count_d = debounce_count_q;
    entered_keys_d   = entered_keys_q;
    entry_position_d = entry_position_q;
    wrong_count_d    = wrong_count_q;
    hash_count_d     = hash_count_q;
    correct_d        = correct_q;
    incorrect_d      = incorrect_q;
    locked_d         = locked_q;
    rel_valid_d      = 1'b0;
    rel_idx_d        = '0;

    if (wrong_count_q < attempt_limit_q) begin
      unique case (scan_phase_q)
        kcl_pkg::PhScanning: begin
          if (scan.found) begin
            last_key_d       = scan.idx;
            debounce_count_d = '0;
            scan_phase_d     = kcl_pkg::PhDebounce;
          end
        end
        kcl_pkg::PhDebounce: begin
          if (debounce_count_q >= debounce_ticks_q) begin
            scan_phase_d = (scan.found && scan.idx == last_key_q) ?
                           kcl_pkg::PhHold : kcl_pkg::PhScanning;
          end
          if (debounce_count_q != 8'hFF) begin
            debounce_count_d = debounce_count_q + 8'd1;
          end
        end
        kcl_pkg::PhHold: begin
          if (!scan.found) begin
            rel_valid_d  = 1'b1;
            rel_idx_d    = last_key_q;
            scan_phase_d = kcl_pkg::PhScanning;
          end else if (scan.idx != last_key_q) begin
            scan_phase_d = kcl_pkg::PhScanning;
          end
        end
        default: begin
          scan_phase_d = kcl_pkg::PhScanning;
        end
      endcase

      if (rel_valid_d && rel_idx_d != kcl_pkg::KeyHash) begin
        entered_keys_d[entry_position_q] = rel_idx_d;
        entry_position_d = (32'(entry_position_q) == CL - 1) ? '0 :
                           entry_position_q + PW'(1);
      end

      if (rel_valid_d && rel_idx_d == kcl_pkg::KeyHash) begin
        if (incorrect_q) begin
          if (hash_count_q) begin
            correct_d        = 1'b0;
            incorrect_d      = 1'b0;
            hash_count_d     = 1'b0;
            entry_position_d = '0;
            for (int i = 0; i < CL; i++) entered_keys_d[i] = kcl_pkg::KeyZero;
          end else begin
            hash_count_d = 1'b1;
          end
        end else if (ring_match) begin
          correct_d        = 1'b1;
          wrong_count_d    = '0;
          entry_position_d = '0;
          for (int i = 0; i < CL; i++) entered_keys_d[i] = kcl_pkg::KeyZero;
        end else begin
          incorrect_d = 1'b1;
          if (wrong_count_q != 4'hF) wrong_count_d = wrong_count_q + 4'd1;
        end
      end
    end else begin
      locked_d = 1'b1;
    end
  end

  always_comb begin
    if (in_acc) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_word_q      <= kcl_pkg::CodeWordRst;
      debounce_ticks_q <= kcl_pkg::DebounceTicksRst;
      attempt_limit_q  <= kcl_pkg::AttemptLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        kcl_pkg::CfgCodeWord:      code_word_q      <= cfg_data_i;
        kcl_pkg::CfgDebounceTicks: debounce_ticks_q <= cfg_data_i[7:0];
        kcl_pkg::CfgAttemptLimit:  attempt_limit_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // state advances only on an accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_phase_q     <= kcl_pkg::PhScanning;
      last_key_q       <= '0;
      debounce_count_q <= '0;
      for (int i = 0; i < CL; i++) entered_keys_q[i] <= kcl_pkg::KeyZero;
      entry_position_q <= '0;
      wrong_count_q    <= '0;
      hash_count_q     <= 1'b0;
      correct_q        <= 1'b0;
      incorrect_q      <= 1'b0;
      locked_q         <= 1'b0;
    end else if (in_acc) begin
      scan_phase_q     <= scan_phase_d;
      last_key_q       <= last_key_d;
      debounce_count_q <= debounce_count_d;
      entered_keys_q   <= entered_keys_d;
      entry_position_q <= entry_position_d;
      wrong_count_q    <= wrong_count_d;
      hash_count_q     <= hash_count_d;
      correct_q        <= correct_d;
      incorrect_q      <= incorrect_d;
      locked_q         <= locked_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rel_valid_q <= 1'b0;
      rel_idx_q   <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        rel_valid_q <= rel_valid_d;
        rel_idx_q   <= rel_idx_d;
      end
    end
  end

  // Flags only change on acceptance, so the state registers double as the
  // result fields of the item held in the output register.
  assign out_valid_o          = out_valid_q;
  assign key_released_valid_o = rel_valid_q;
  assign key_released_index_o = rel_idx_q;
  assign code_correct_o       = correct_q;
  assign code_incorrect_o     = incorrect_q;
  assign locked_out_o         = locked_q;
  assign wrong_attempts_o     = wrong_count_q;

  // Lockout is sticky until reset.
  a_locked_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    locked_q |=> locked_q)
    else $error("locked flag dropped");

  // A locked block leaves the wrong count alone.
  a_locked_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && locked_q) |=> $stable(wrong_count_q))
    else $error("wrong count changed while locked");

  // A release always sends the debounce machine back to scanning.
  a_release_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && rel_valid_q) |-> scan_phase_q == kcl_pkg::PhScanning)
    else $error("release without return to scanning");

  // A correct code clears the wrong count.
  a_correct_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(correct_q) |-> wrong_count_q == 4'd0)
    else $error("correct code left wrong count set");

endmodule
